// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge; disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an expression holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    `ASSERT_CLK(label, 1'b1 |-> (expr), msg)

`endif

// ===== rtl/icrl_pkg.sv =====
// Types and constants for the input current ramp limiter.
// No dependencies; used by icrl_step and input_current_ramp_limiter.
package icrl_pkg;

    localparam int CURRENT_BITS = 13;
    localparam int STEP_BITS    = 10;
    localparam int DELAY_BITS   = 16;
    localparam int OP_BITS      = 2;
    localparam int CFG_DATA_BITS = DELAY_BITS;

    localparam logic [OP_BITS-1:0] OP_TICK         = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SET_CHARGER  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SET_RECEIVER = 2'd2;

    localparam logic REG_STEP_MA     = 1'b0;
    localparam logic REG_DELAY_TICKS = 1'b1;

    localparam logic [CURRENT_BITS-1:0] RESET_SETPOINT = CURRENT_BITS'(100);
    localparam logic [CURRENT_BITS-1:0] NO_LIMIT       = '1;

    typedef struct packed {
        logic [OP_BITS-1:0]      operation;
        logic [CURRENT_BITS-1:0] limit_ma;
    } t_in_req;

    typedef struct packed {
        logic [CURRENT_BITS-1:0] setpoint_ma;
        logic                    write_strobe;
        logic                    ramp_busy;
    } t_out_rsp;

    typedef struct packed {
        logic [CURRENT_BITS-1:0] setpoint;
        logic [CURRENT_BITS-1:0] charger_limit;
        logic [CURRENT_BITS-1:0] receiver_limit;
        logic [CURRENT_BITS-1:0] target;
        logic [DELAY_BITS-1:0]   tick_count;
        logic                    ramping;
    } t_state;

endpackage

// ===== rtl/icrl_step.sv =====
// Next-state and result logic for one request of the ramp limiter.
// Depends on icrl_pkg.
module icrl_step (
    input  icrl_pkg::t_state                    i_state,
    input  logic [icrl_pkg::STEP_BITS-1:0]      i_step_ma,
    input  logic [icrl_pkg::DELAY_BITS-1:0]     i_delay_ticks,
    input  icrl_pkg::t_in_req                   i_req,
    output icrl_pkg::t_state                    o_state,
    output icrl_pkg::t_out_rsp                  o_rsp
);

    logic                                  ramp_en;
    logic [icrl_pkg::CURRENT_BITS-1:0]     new_target;
    logic [icrl_pkg::CURRENT_BITS-1:0]     diff_up;
    logic [icrl_pkg::CURRENT_BITS-1:0]     diff_dn;
    logic [icrl_pkg::CURRENT_BITS-1:0]     step_ext;
    logic [icrl_pkg::DELAY_BITS-1:0]       tick_inc;
    logic                                  strobe;

    assign ramp_en  = (i_step_ma != '0) && (i_delay_ticks != '0);
    assign step_ext = icrl_pkg::CURRENT_BITS'(i_step_ma);
    assign diff_up  = i_state.target - i_state.setpoint;
    assign diff_dn  = i_state.setpoint - i_state.target;
    assign tick_inc = i_state.tick_count + 1'b1;

    always_comb begin
        o_state    = i_state;
        strobe     = 1'b0;
        new_target = i_req.limit_ma;
        case (i_req.operation)
            icrl_pkg::OP_SET_CHARGER, icrl_pkg::OP_SET_RECEIVER: begin
                if (i_req.operation == icrl_pkg::OP_SET_CHARGER) begin
                    o_state.charger_limit = i_req.limit_ma;
                    if (i_state.receiver_limit < i_req.limit_ma) begin
                        new_target = i_state.receiver_limit;
                    end
                end else begin
                    o_state.receiver_limit = i_req.limit_ma;
                    if (i_state.charger_limit < i_req.limit_ma) begin
                        new_target = i_state.charger_limit;
                    end
                end
                if (ramp_en) begin
                    o_state.target     = new_target;
                    o_state.tick_count = '0;
                    o_state.ramping    = (new_target != i_state.setpoint);
                    strobe             = 1'b1;
                end
            end
            icrl_pkg::OP_TICK: begin
                if (i_state.ramping) begin
                    strobe = 1'b1;
                    if (!ramp_en) begin
                        o_state.setpoint   = i_state.target;
                        o_state.ramping    = 1'b0;
                        o_state.tick_count = '0;
                    end else if (tick_inc >= i_delay_ticks) begin
                        o_state.tick_count = '0;
                        if (i_state.setpoint < i_state.target) begin
                            if (diff_up <= step_ext) begin
                                o_state.setpoint = i_state.target;
                                o_state.ramping  = 1'b0;
                            end else begin
                                o_state.setpoint = i_state.setpoint + step_ext;
                            end
                        end else if (i_state.setpoint > i_state.target) begin
                            if (diff_dn <= step_ext) begin
                                o_state.setpoint = i_state.target;
                                o_state.ramping  = 1'b0;
                            end else begin
                                o_state.setpoint = i_state.setpoint - step_ext;
                            end
                        end else begin
                            o_state.ramping = 1'b0;
                        end
                    end else begin
                        o_state.tick_count = tick_inc;
                        strobe             = 1'b0;
                    end
                end
            end
            default: begin
                strobe = 1'b0;
            end
        endcase
    end

    assign o_rsp.setpoint_ma  = o_state.setpoint;
    assign o_rsp.write_strobe = strobe;
    assign o_rsp.ramp_busy    = o_state.ramping;

endmodule

// ===== rtl/input_current_ramp_limiter.sv =====
// Input current ramp limiter: top level with request/result registers and state.
// Depends on icrl_pkg, icrl_step and assert_macros.svh.
//
// Each request (tick or limit update) produces one result. A request is held in an
// input register, evaluated by one pass of compare/add logic against the ramp state,
// and the result lands in an output register, so a request is taken every cycle;
// throughput drops only while the output register is stalled. Write step_ma and
// delay_ticks only when no requests are in flight; a zero in either makes limit
// updates store the limit only.
`include "assert_macros.svh"

module input_current_ramp_limiter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  icrl_pkg::t_in_req                    i_in_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output icrl_pkg::t_out_rsp                   o_out_rsp,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_idx,
    input  logic [icrl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic                                r_in_valid;
    icrl_pkg::t_in_req                   r_in;
    logic                                r_out_valid;
    icrl_pkg::t_out_rsp                  r_out;
    icrl_pkg::t_state                    r_state;
    icrl_pkg::t_state                    n_state;
    icrl_pkg::t_out_rsp                  n_out;
    logic [icrl_pkg::STEP_BITS-1:0]      r_step_ma;
    logic [icrl_pkg::DELAY_BITS-1:0]     r_delay_ticks;
    logic                                advance;
    logic                                take_in;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in    = i_in_valid && o_in_ready;

    icrl_step u_step (
        .i_state       (r_state),
        .i_step_ma     (r_step_ma),
        .i_delay_ticks (r_delay_ticks),
        .i_req         (r_in),
        .o_state       (n_state),
        .o_rsp         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_step_ma             <= '0;
            r_delay_ticks         <= '0;
            r_state.setpoint      <= icrl_pkg::RESET_SETPOINT;
            r_state.charger_limit <= '0;
            r_state.receiver_limit <= icrl_pkg::NO_LIMIT;
            r_state.target        <= icrl_pkg::RESET_SETPOINT;
            r_state.tick_count    <= '0;
            r_state.ramping       <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    icrl_pkg::REG_STEP_MA:     r_step_ma     <= i_cfg_data[icrl_pkg::STEP_BITS-1:0];
                    icrl_pkg::REG_DELAY_TICKS: r_delay_ticks <= i_cfg_data;
                    default: begin
                        r_step_ma <= r_step_ma;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_req;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `ASSERT_CLK(a_setpoint_strobed, ($past(i_rst_n) && !$stable(r_state.setpoint)) |-> (r_out_valid && r_out.write_strobe), "setpoint changed without a write strobe")
    `ASSERT_ALWAYS(a_idle_on_target, r_state.ramping || (r_state.setpoint == r_state.target), "ramp idle but setpoint off target")
    `ASSERT_CLK(a_stall_only_on_output, !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready), "input stalled without output backpressure")

endmodule
